/* rtl/assert_macros.svh */
// concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) (expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, expr, msg)
`endif

`endif

/* rtl/pctc_pkg.sv */
`timescale 1ns / 1ps

package pctc_pkg;

  localparam int DEF_MAX_VOCAB  = 65536;
  localparam int DEF_MAX_WINDOW = 64;
  localparam int DEF_ACC_WIDTH  = 48;

  localparam int VOCAB_REG_W  = 17;
  localparam int WINDOW_REG_W = 7;
  localparam int BLANK_W      = 16;
  localparam int LOGIT_W      = 16;
  localparam int WEIGHT_W     = 17;
  localparam int TOTAL_W      = 24;
  localparam int PROD_W       = LOGIT_W + WEIGHT_W + 1;
  localparam int WINNER_W     = 17;
  localparam int TOKEN_W      = 16;
  localparam int QUEUE_DEPTH  = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 17;

  localparam logic [VOCAB_REG_W-1:0]  VOCAB_RST  = 17'h10000;
  localparam logic [WINDOW_REG_W-1:0] WINDOW_RST = 7'd4;
  localparam logic [BLANK_W-1:0]      BLANK_RST  = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOCAB_LEN     = 2'd0,
    REG_WINDOW_FRAMES = 2'd1,
    REG_BLANK_INDEX   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [VOCAB_REG_W-1:0]  vocab_len;
    logic [WINDOW_REG_W-1:0] window_frames;
    logic [BLANK_W-1:0]      blank_index;
  } cfg_t;

  typedef struct packed {
    logic first_frame;
    logic elem0;
    logic close;
    logic utt_end;
    logic total_zero;
  } item_flags_t;

endpackage

/* rtl/pctc_fifo.sv */
`timescale 1ns / 1ps

module pctc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/pctc_front.sv */
`timescale 1ns / 1ps

module pctc_front import pctc_pkg::*; #(
  parameter int MAX_VOCAB  = DEF_MAX_VOCAB,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_t                         cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [LOGIT_W-1:0]    logit_i,
  input  logic [WEIGHT_W-1:0]          weight_i,
  input  logic                         utterance_end_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output logic [$clog2(MAX_VOCAB)-1:0] idx_o,
  output logic signed [LOGIT_W-1:0]    logit_o,
  output logic [WEIGHT_W-1:0]          weight_o,
  output item_flags_t                  flags_o
);

  localparam int IDX_W = $clog2(MAX_VOCAB);
  localparam int VCW   = $clog2(MAX_VOCAB+1);
  localparam int VW    = (VCW > VOCAB_REG_W) ? VCW : VOCAB_REG_W;
  localparam int WCW   = $clog2(MAX_WINDOW+1);
  localparam int WW    = (WCW > WINDOW_REG_W) ? WCW : WINDOW_REG_W;
  localparam int FIW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [IDX_W-1:0]    elem_q, elem_d;
  logic [FIW-1:0]      fiw_q, fiw_d;
  logic [WEIGHT_W-1:0] fw_q, fw_d;
  logic [TOTAL_W-1:0]  total_q, total_d;

  logic [VW-1:0]       vsz, veff;
  logic [WW-1:0]       wsz, weff;
  logic                elem0, first_frame, last_elem, last_frame, close;
  logic [TOTAL_W:0]    total_sum;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  // effective sizes: zero acts as one, clamp to the built maximum
  assign vsz  = VW'(cfg_i.vocab_len);
  assign veff = (vsz == '0) ? VW'(1) : ((vsz > VW'(MAX_VOCAB)) ? VW'(MAX_VOCAB) : vsz);
  assign wsz  = WW'(cfg_i.window_frames);
  assign weff = (wsz == '0) ? WW'(1) : ((wsz > WW'(MAX_WINDOW)) ? WW'(MAX_WINDOW) : wsz);

  assign elem0       = (elem_q == '0);
  assign first_frame = (fiw_q == '0);
  assign last_elem   = (VW'(elem_q) + VW'(1)) >= veff;
  assign last_frame  = (WW'(fiw_q) + WW'(1)) >= weff;
  assign close       = utterance_end_i || (last_elem && last_frame);
  assign total_sum   = {1'b0, total_q} + (TOTAL_W+1)'(weight_i);

  always_comb begin
    fw_d    = fw_q;
    total_d = total_q;
    elem_d  = elem_q;
    fiw_d   = fiw_q;
    if (elem0) begin
      fw_d = weight_i;
      if (first_frame) begin
        total_d = TOTAL_W'(weight_i);
      end else begin
        total_d = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
      end
    end
    if (last_elem || utterance_end_i) begin
      elem_d = '0;
      fiw_d  = close ? '0 : fiw_q + 1'b1;
    end else begin
      elem_d = elem_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q  <= '0;
      fiw_q   <= '0;
      fw_q    <= '0;
      total_q <= '0;
    end else if (push_o) begin
      elem_q  <= elem_d;
      fiw_q   <= fiw_d;
      fw_q    <= fw_d;
      total_q <= total_d;
    end
  end

  assign idx_o               = elem_q;
  assign logit_o             = logit_i;
  assign weight_o            = fw_d;
  assign flags_o.first_frame = first_frame;
  assign flags_o.elem0       = elem0;
  assign flags_o.close       = close;
  assign flags_o.utt_end     = utterance_end_i;
  assign flags_o.total_zero  = (total_d == '0);

endmodule

/* rtl/pctc_back.sv */
`timescale 1ns / 1ps

module pctc_back import pctc_pkg::*; #(
  parameter int MAX_VOCAB = DEF_MAX_VOCAB,
  parameter int ACC_WIDTH = DEF_ACC_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [BLANK_W-1:0]           blank_index_i,
  input  logic                         q_empty_i,
  input  logic [$clog2(MAX_VOCAB)-1:0] q_idx_i,
  input  logic signed [LOGIT_W-1:0]    q_logit_i,
  input  logic [WEIGHT_W-1:0]          q_weight_i,
  input  item_flags_t                  q_flags_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [TOKEN_W-1:0]           token_id_o,
  output logic                         token_new_o,
  output logic                         utterance_end_res_o
);

  localparam int IDX_W = $clog2(MAX_VOCAB);
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic signed [ACC_WIDTH-1:0] acc_mem [MAX_VOCAB];

  logic                        s1_valid_q;
  logic [IDX_W-1:0]            s1_idx_q;
  logic signed [PROD_W-1:0]    s1_prod_q;
  item_flags_t                 s1_flags_q;
  logic signed [ACC_WIDTH-1:0] rd_q;
  logic                        fwd_q;
  logic signed [ACC_WIDTH-1:0] fwd_val_q;

  logic signed [ACC_WIDTH-1:0] best_q;
  logic [IDX_W-1:0]            best_idx_q;
  logic [WINNER_W-1:0]         prev_q;

  logic                        out_valid_q;
  logic [TOKEN_W-1:0]          token_q;
  logic                        token_new_q;
  logic                        utt_end_q;

  logic signed [PROD_W-1:0]    prod_d;
  logic                        out_free, s1_adv;
  logic signed [ACC_WIDTH-1:0] acc_old, prod_ext, acc_new;
  logic [ACC_WIDTH:0]          sum;
  logic                        take, is_new;
  logic [IDX_W-1:0]            best_idx_cur;
  logic [WINNER_W-1:0]         blank_ext, winner, token_full;

  assign out_free = !out_valid_q || out_ready_i;
  assign s1_adv   = s1_valid_q && (!s1_flags_q.close || out_free);
  assign q_pop_o  = !q_empty_i && (!s1_valid_q || s1_adv);

  assign prod_d = PROD_W'(q_logit_i) * PROD_W'($signed({1'b0, q_weight_i}));

  // saturating accumulate, first frame of a window overwrites
  assign acc_old  = fwd_q ? fwd_val_q : rd_q;
  assign prod_ext = {{(ACC_WIDTH-PROD_W){s1_prod_q[PROD_W-1]}}, s1_prod_q};
  assign sum      = {acc_old[ACC_WIDTH-1], acc_old} + {prod_ext[ACC_WIDTH-1], prod_ext};

  always_comb begin
    if (s1_flags_q.first_frame) begin
      acc_new = prod_ext;
    end else if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
      acc_new = sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_new = sum[ACC_WIDTH-1:0];
    end
  end

  assign take         = s1_flags_q.elem0 || (acc_new > best_q);
  assign best_idx_cur = take ? s1_idx_q : best_idx_q;
  assign blank_ext    = WINNER_W'(blank_index_i);
  assign winner       = s1_flags_q.total_zero ? blank_ext : WINNER_W'(best_idx_cur);
  assign is_new       = (winner != blank_ext) && (winner != prev_q);
  assign token_full   = winner - ((blank_index_i == '0) ? WINNER_W'(1) : WINNER_W'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      best_q      <= '0;
      best_idx_q  <= '0;
      prev_q      <= '1;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= q_pop_o || (s1_valid_q && !s1_adv);
      if (q_pop_o) begin
        fwd_q <= s1_adv && (s1_idx_q == q_idx_i);
      end
      if (s1_adv) begin
        if (take) begin
          best_q     <= acc_new;
          best_idx_q <= s1_idx_q;
        end
        if (s1_flags_q.close) begin
          prev_q <= s1_flags_q.utt_end ? '1 : winner;
        end
      end
      if (s1_adv && s1_flags_q.close) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_idx_q   <= q_idx_i;
      s1_prod_q  <= prod_d;
      s1_flags_q <= q_flags_i;
      rd_q       <= acc_mem[q_idx_i];
      fwd_val_q  <= acc_new;
    end
    if (s1_adv) begin
      acc_mem[s1_idx_q] <= acc_new;
    end
    if (s1_adv && s1_flags_q.close) begin
      token_q     <= is_new ? token_full[TOKEN_W-1:0] : '0;
      token_new_q <= is_new;
      utt_end_q   <= s1_flags_q.utt_end;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign token_id_o          = token_q;
  assign token_new_o         = token_new_q;
  assign utterance_end_res_o = utt_end_q;

endmodule

/* rtl/pooled_ctc_greedy_decoder.sv */
`timescale 1ns / 1ps
// pooled ctc greedy decoder
// input channel: one logit beat per vocabulary element, in index order, frame
// after frame; weight is taken on element zero, utterance_end_i on the last
// element of the utterance. config channel: cfg_index_i selects vocab size,
// window frames or blank index, cfg_data_i carries the value; write only idle.
// output channel: one beat per closed window (token, new flag, utterance end).
// throughput: one input beat per cycle while the queue has room, set by the
// accumulator memory with one read and one write port, one-deep forwarding
// covers a repeated index. path: a closing element passes the classifier
// into a four-entry queue, then the accumulate stage, then the output register.
// reset: counters and window state clear, previous winner becomes none,
// registers return to vocab 65536, window 4, blank 0; the accumulator
// memory is not cleared and needs no sweep (first frame overwrites).
// stall: while the output register is held, the accumulate stage keeps
// working until a closing element arrives; the queue then fills and
// in_ready_o falls when it is full.
module pooled_ctc_greedy_decoder import pctc_pkg::*; #(
  parameter int MAX_VOCAB  = DEF_MAX_VOCAB,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int ACC_WIDTH  = DEF_ACC_WIDTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [LOGIT_W-1:0] logit_i,
  input  logic [WEIGHT_W-1:0]       weight_i,
  input  logic                      utterance_end_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [TOKEN_W-1:0]        token_id_o,
  output logic                      token_new_o,
  output logic                      utterance_end_res_o
);

`include "assert_macros.svh"

  localparam int IDX_W  = $clog2(MAX_VOCAB);
  localparam int FLAG_W = $bits(item_flags_t);
  localparam int QW     = IDX_W + LOGIT_W + WEIGHT_W + FLAG_W;
  localparam int QCW    = $clog2(QUEUE_DEPTH+1);

  cfg_t cfg_q;

  logic                      q_push, q_pop, q_full, q_empty;
  logic [QCW-1:0]            q_cnt;
  logic [QW-1:0]             q_wdata, q_rdata;
  logic [IDX_W-1:0]          f_idx, h_idx;
  logic signed [LOGIT_W-1:0] f_logit, h_logit;
  logic [WEIGHT_W-1:0]       f_weight, h_weight;
  item_flags_t               f_flags, h_flags;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vocab_len     <= VOCAB_RST;
      cfg_q.window_frames <= WINDOW_RST;
      cfg_q.blank_index   <= BLANK_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_VOCAB_LEN:     cfg_q.vocab_len     <= cfg_data_i[VOCAB_REG_W-1:0];
        REG_WINDOW_FRAMES: cfg_q.window_frames <= cfg_data_i[WINDOW_REG_W-1:0];
        REG_BLANK_INDEX:   cfg_q.blank_index   <= cfg_data_i[BLANK_W-1:0];
        default: ;
      endcase
    end
  end

  pctc_front #(
    .MAX_VOCAB  (MAX_VOCAB),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .logit_i         (logit_i),
    .weight_i        (weight_i),
    .utterance_end_i (utterance_end_i),
    .q_full_i        (q_full),
    .push_o          (q_push),
    .idx_o           (f_idx),
    .logit_o         (f_logit),
    .weight_o        (f_weight),
    .flags_o         (f_flags)
  );

  assign q_wdata = {f_idx, f_logit, f_weight, f_flags};
  assign {h_idx, h_logit, h_weight, h_flags} = q_rdata;

  pctc_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty),
    .count_o (q_cnt)
  );

  pctc_back #(
    .MAX_VOCAB (MAX_VOCAB),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .blank_index_i       (cfg_q.blank_index),
    .q_empty_i           (q_empty),
    .q_idx_i             (h_idx),
    .q_logit_i           (h_logit),
    .q_weight_i          (h_weight),
    .q_flags_i           (h_flags),
    .q_pop_o             (q_pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .token_id_o          (token_id_o),
    .token_new_o         (token_new_o),
    .utterance_end_res_o (utterance_end_res_o)
  );

  `ASSERT_ALWAYS(a_queue_bound, q_cnt <= QCW'(QUEUE_DEPTH), "queue level above depth")
  `ASSERT_PROP(a_pop_nonempty, q_pop |-> (q_cnt != '0), "pop from empty queue")
  `ASSERT_PROP(a_q_grows, (q_push && !q_pop) |=> (q_cnt == $past(q_cnt) + 1'b1), "queue miscount")
  `ASSERT_PROP(a_tok_zero, (out_valid_o && !token_new_o) |-> (token_id_o == '0), "stray token id")

endmodule
